@@ rtl/core/drxat_pkg.sv @@
package drxat_pkg;

  localparam int SLOT_WRAP_DEF = 20480;

  // action codes of an event word
  localparam logic [2:0] ACT_TICK     = 3'd0;
  localparam logic [2:0] ACT_DL_PDCCH = 3'd1;
  localparam logic [2:0] ACT_UL_PDCCH = 3'd2;
  localparam logic [2:0] ACT_DL_NACK  = 3'd3;
  localparam logic [2:0] ACT_CONRES   = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_CYCLE_LEN      = 3'd0;
  localparam logic [2:0] REG_ON_START       = 3'd1;
  localparam logic [2:0] REG_ON_DURATION    = 3'd2;
  localparam logic [2:0] REG_INACTIVITY_LEN = 3'd3;
  localparam logic [2:0] REG_RETX_UL_LEN    = 3'd4;
  localparam logic [2:0] REG_RETX_DL_LEN    = 3'd5;
  localparam logic [2:0] REG_CONRES_LEN     = 3'd6;
  localparam logic [2:0] REG_CCCH_SLOT      = 3'd7;

  localparam logic [14:0] CCCH_SLOT_RESET = 15'd20480;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP_GO,
    ST_WRAP_WAIT,
    ST_CHECK,
    ST_MOD_GO,
    ST_MOD_WAIT,
    ST_WIN,
    ST_SUM_GO,
    ST_SUM_WAIT,
    ST_APPLY,
    ST_APPLY2,
    ST_DONE
  } state_t;

endpackage

@@ rtl/core/drxat_in_if.sv @@
interface drxat_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [14:0] slot;
  logic [14:0] ul_tx_slot;
  logic        sr_pending;

  modport source (output valid, action, slot, ul_tx_slot, sr_pending, input ready);
  modport sink (input valid, action, slot, ul_tx_slot, sr_pending, output ready);
endinterface

@@ rtl/core/drxat_out_if.sv @@
interface drxat_out_if;
  logic        valid;
  logic        ready;
  logic        pdcch_enabled;
  logic        end_valid;
  logic [14:0] end_slot;
  logic        conres_error;

  modport source (output valid, pdcch_enabled, end_valid, end_slot, conres_error,
                  input ready);
  modport sink (input valid, pdcch_enabled, end_valid, end_slot, conres_error,
                output ready);
endinterface

@@ rtl/core/drx_active_time_tracker.sv @@
// DRX active-time tracker for one UE. Each event word (slot tick, DL or UL PDCCH, DL HARQ
// NACK, contention-resolution start) gives exactly one result word with the PDCCH-enabled
// flag and the held active-time end slot after the event. All slot arithmetic wraps at
// SLOT_WRAP and runs on two bit-serial remainder units that take one dividend bit per
// cycle, XW = clog2(SLOT_WRAP + 65536) bits per pass (17 at the default wrap). A slot
// tick that opens an on-duration window takes three passes (slot wrap, window, sum); a
// tick that misses the window takes two (slot wrap, window); PDCCH, NACK and
// contention-resolution events that can extend take two (slot wrap, sum); an event that
// changes nothing early (DRX disabled, tick inside a held end, PDCCH outside active time,
// unregistered CCCH slot, unknown action) takes one. A full output register that is not
// drained holds the block in its done state. One event is in work at a time; a new event
// is taken while the previous result still waits on the output register.
// Configuration is written through cfg_wr_en / cfg_index / cfg_data and must only change
// while the block is idle.
module drx_active_time_tracker
  import drxat_pkg::*;
#(
  parameter int SLOT_WRAP = SLOT_WRAP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data,
  drxat_in_if.sink    evt,
  drxat_out_if.source res
);

  localparam int SW  = $clog2(SLOT_WRAP);
  localparam int DWW = $clog2(SLOT_WRAP + 1);
  localparam int DW  = (DWW > 15) ? DWW : 15;
  localparam int XW  = $clog2(SLOT_WRAP + 65536);
  localparam logic [DW-1:0] WRAP_D = DW'(SLOT_WRAP);
  localparam logic [SW:0]   WRAP_S = (SW + 1)'(SLOT_WRAP);
  localparam logic [SW:0]   HALF_S = (SW + 1)'(SLOT_WRAP / 2);

  // configuration
  logic [14:0] cycle_len;
  logic [14:0] on_start;
  logic [14:0] on_duration;
  logic [14:0] inactivity_len;
  logic [9:0]  retx_ul_len;
  logic [9:0]  retx_dl_len;
  logic [9:0]  conres_len;
  logic [14:0] ccch_slot;

  state_t state, state_next;

  logic [2:0]    act;
  logic [14:0]   slot_raw;
  logic [14:0]   pusch_raw;
  logic          sr;
  logic          err;
  logic [SW-1:0] base;
  logic [SW-1:0] pusch_w;
  logic [15:0]   delta;
  logic          end_held;
  logic [SW-1:0] end_time;

  logic          o_valid;
  logic          o_pdcch;
  logic          o_end_valid;
  logic [14:0]   o_end_slot;
  logic          o_err;

  logic          start_a, start_b;
  logic [XW-1:0] dvd_a, dvd_b;
  logic [DW-1:0] dvs_a, dvs_b;
  logic          busy_a, busy_b;
  logic [DW-1:0] rem_a, rem_b;

  logic          drx_on;
  logic          ccch_none;
  logic [15:0]   stop;
  logic [14:0]   m;
  logic [14:0]   stop_m;
  logic          win_in;
  logic          win_wrap;
  logic          out_load;

  // circular a-before-b on the slot counter
  function automatic logic slot_before(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW:0] d;
    if (b >= a) begin
      d = {1'b0, b} - {1'b0, a};
    end else begin
      d = {1'b0, b} + WRAP_S - {1'b0, a};
    end
    return (d != '0) && (d < HALF_S);
  endfunction

  assign drx_on    = (cycle_len != '0);
  assign ccch_none = (DW'(ccch_slot) >= WRAP_D);
  assign stop      = 16'(on_start) + 16'(on_duration);
  assign m         = 15'(rem_a);
  assign stop_m    = 15'(rem_b);
  assign win_in    = (m >= on_start) && (16'(m) < stop);
  assign win_wrap  = (stop >= 16'(cycle_len)) && (m < stop_m);
  assign out_load  = (state == ST_DONE) && (!o_valid || res.ready);

  drxat_srem #(.XW(XW), .DW(DW)) u_rem_a (
    .clk      (clk),
    .rst      (rst),
    .start    (start_a),
    .dividend (dvd_a),
    .divisor  (dvs_a),
    .busy     (busy_a),
    .rem      (rem_a)
  );

  drxat_srem #(.XW(XW), .DW(DW)) u_rem_b (
    .clk      (clk),
    .rst      (rst),
    .start    (start_b),
    .dividend (dvd_b),
    .divisor  (dvs_b),
    .busy     (busy_b),
    .rem      (rem_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_len      <= '0;
      on_start       <= '0;
      on_duration    <= '0;
      inactivity_len <= '0;
      retx_ul_len    <= '0;
      retx_dl_len    <= '0;
      conres_len     <= '0;
      ccch_slot      <= CCCH_SLOT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CYCLE_LEN:      cycle_len      <= cfg_data;
        REG_ON_START:       on_start       <= cfg_data;
        REG_ON_DURATION:    on_duration    <= cfg_data;
        REG_INACTIVITY_LEN: inactivity_len <= cfg_data;
        REG_RETX_UL_LEN:    retx_ul_len    <= cfg_data[9:0];
        REG_RETX_DL_LEN:    retx_dl_len    <= cfg_data[9:0];
        REG_CONRES_LEN:     conres_len     <= cfg_data[9:0];
        REG_CCCH_SLOT:      ccch_slot      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (evt.valid) state_next = ST_WRAP_GO;
      ST_WRAP_GO:   state_next = ST_WRAP_WAIT;
      ST_WRAP_WAIT: if (!busy_a && !busy_b) state_next = ST_CHECK;
      ST_CHECK: begin
        state_next = ST_DONE;
        if (drx_on) begin
          case (act)
            ACT_TICK: begin
              if (!end_held || !slot_before(base, end_time)) state_next = ST_MOD_GO;
            end
            ACT_DL_PDCCH, ACT_UL_PDCCH: begin
              if (end_held || sr) state_next = ST_SUM_GO;
            end
            ACT_DL_NACK: state_next = ST_SUM_GO;
            ACT_CONRES: begin
              if (!ccch_none) state_next = ST_SUM_GO;
            end
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_MOD_GO:   state_next = ST_MOD_WAIT;
      ST_MOD_WAIT: if (!busy_a && !busy_b) state_next = ST_WIN;
      ST_WIN:      state_next = (win_in || win_wrap) ? ST_SUM_GO : ST_DONE;
      ST_SUM_GO:   state_next = ST_SUM_WAIT;
      ST_SUM_WAIT: if (!busy_a && !busy_b) state_next = ST_APPLY;
      ST_APPLY:    state_next = ST_APPLY2;
      ST_APPLY2:   state_next = ST_DONE;
      ST_DONE:     if (!o_valid || res.ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    evt.ready = (state == ST_IDLE);
    start_a   = state inside {ST_WRAP_GO, ST_MOD_GO, ST_SUM_GO};
    start_b   = start_a;
    dvd_a     = XW'(base) + XW'(delta);
    dvd_b     = XW'(pusch_w) + XW'(retx_ul_len);
    dvs_a     = WRAP_D;
    dvs_b     = WRAP_D;
    case (state)
      ST_WRAP_GO: begin
        dvd_a = XW'(slot_raw);
        dvd_b = XW'(pusch_raw);
      end
      ST_MOD_GO: begin
        // slot mod cycle and window stop mod cycle side by side
        dvd_a = XW'(base);
        dvd_b = XW'(stop);
        dvs_a = DW'(cycle_len);
        dvs_b = DW'(cycle_len);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      end_held <= 1'b0;
      end_time <= '0;
      err      <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (evt.valid) begin
            act       <= evt.action;
            slot_raw  <= evt.slot;
            pusch_raw <= evt.ul_tx_slot;
            sr        <= evt.sr_pending;
            err       <= 1'b0;
          end
        end
        ST_WRAP_WAIT: begin
          base    <= SW'(rem_a);
          pusch_w <= SW'(rem_b);
        end
        ST_CHECK: begin
          if (drx_on) begin
            case (act)
              ACT_TICK: begin
                if (end_held && !slot_before(base, end_time)) begin
                  end_held <= 1'b0;
                  end_time <= '0;
                end
              end
              ACT_DL_PDCCH, ACT_UL_PDCCH: delta <= 16'(inactivity_len);
              ACT_DL_NACK:                delta <= 16'(retx_dl_len);
              ACT_CONRES: begin
                if (ccch_none) begin
                  err <= 1'b1;
                end else begin
                  base  <= SW'(ccch_slot);
                  delta <= 16'(conres_len);
                end
              end
              default: ;
            endcase
          end
        end
        ST_WIN: begin
          if (win_in) begin
            delta <= stop - 16'(m);
          end else begin
            delta <= 16'(stop_m - m);
          end
        end
        ST_APPLY: begin
          case (act)
            ACT_TICK: begin
              end_held <= 1'b1;
              end_time <= SW'(rem_a);
            end
            ACT_DL_PDCCH, ACT_UL_PDCCH: begin
              if ((inactivity_len != '0) &&
                  (!end_held || slot_before(end_time, SW'(rem_a)))) begin
                end_held <= 1'b1;
                end_time <= SW'(rem_a);
              end
            end
            ACT_DL_NACK: begin
              if ((retx_dl_len != '0) &&
                  (!end_held || slot_before(end_time, SW'(rem_a)))) begin
                end_held <= 1'b1;
                end_time <= SW'(rem_a);
              end
            end
            ACT_CONRES: begin
              if (!end_held || slot_before(end_time, SW'(rem_a))) begin
                end_held <= 1'b1;
                end_time <= SW'(rem_a);
              end
            end
            default: ;
          endcase
        end
        ST_APPLY2: begin
          // ul retransmission window goes on top of the inactivity extension
          if ((act == ACT_UL_PDCCH) && (retx_ul_len != '0) &&
              (!end_held || slot_before(end_time, SW'(rem_b)))) begin
            end_held <= 1'b1;
            end_time <= SW'(rem_b);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_load) begin
      o_valid <= 1'b1;
    end else if (res.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_pdcch     <= !drx_on || end_held || sr;
      o_end_valid <= end_held;
      o_end_slot  <= end_held ? 15'(end_time) : '0;
      o_err       <= err;
    end
  end

  assign res.valid         = o_valid;
  assign res.pdcch_enabled = o_pdcch;
  assign res.end_valid     = o_end_valid;
  assign res.end_slot      = o_end_slot;
  assign res.conres_error  = o_err;

`ifndef SYNTHESIS
  a_end_in_range: assert property (@(posedge clk) disable iff (rst)
    end_held |-> ({1'b0, end_time} < WRAP_S))
    else $error("held end slot beyond wrap");

  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!busy_a && !busy_b))
    else $error("remainder unit busy while idle");

  a_empty_end_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.end_valid) |-> (res.end_slot == '0))
    else $error("end slot reported without a held end");

  a_err_needs_drx: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.conres_error) |-> drx_on)
    else $error("conres error with drx disabled");

  a_pdcch_when_off: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !drx_on) |-> res.pdcch_enabled)
    else $error("pdcch gated with drx disabled");

  a_tick_sets_end: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_APPLY) && (act == ACT_TICK)) |=> end_held)
    else $error("window hit did not set an end");
`endif

endmodule

@@ rtl/core/drxat_srem.sv @@
module drxat_srem #(
  parameter int XW = 17,
  parameter int DW = 15
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [XW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(XW + 1);

  logic [XW-1:0] sh;
  logic [DW-1:0] r;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  // restoring remainder, one dividend bit per cycle, msb first
  assign trial = {r, sh[XW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign busy  = (cnt != '0);
  assign rem   = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(XW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= dividend;
      r   <= '0;
      dvs <= divisor;
    end else if (busy) begin
      sh <= sh << 1;
      if (trial >= {1'b0, dvs}) begin
        r <= DW'(diff);
      end else begin
        r <= DW'(trial);
      end
    end
  end

endmodule
